// ----- hdl/nce_pkg.sv -----
// Shared widths, codes and helpers for the NURBS curve evaluator.
`default_nettype none
package nce_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int NPTS_W     = 7;
  localparam int MAX_DEGREE = 7;
  localparam int DEG_W      = 3;
  localparam int FRAC_BITS  = 16;
  localparam int ONE_W      = FRAC_BITS + 1;
  localparam int COORD_W    = 32;
  // Homogeneous work values: x*w/ONE needs 48 bits, keep headroom.
  localparam int D_W        = 50;
  // Positive part of a blended weight.
  localparam int W_W        = 34;
  // Scaled parameter t*m and alpha numerator/quotient.
  localparam int AQ_W       = 24;
  localparam int ADIV_STEPS = 8;
  localparam int ADIV_CYC   = AQ_W / ADIV_STEPS;

  localparam logic [ONE_W-1:0] ONE_Q = ONE_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CFG     = 2'd1,
    ST_WEIGHT_ZERO = 2'd2,
    ST_HOMOG_ZERO  = 2'd3
  } nce_status_e;

  localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [1:0] REG_CURVE_DEGREE = 2'd1;
  localparam logic [1:0] REG_RATIONAL     = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic [3:0][D_W-1:0] nce_hpoint_t;

  // Saturate a wide signed value to a signed 32-bit word.
  function automatic logic [COORD_W-1:0] sat32(input logic signed [D_W-1:0] v);
    logic signed [D_W-1:0] hi;
    logic signed [D_W-1:0] lo;
    hi = $signed({{(D_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    lo = $signed({{(D_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
    if (v > hi) begin
      sat32 = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[COORD_W-1:0];
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/nce_alpha_div.sv -----
// Alpha divider: small-divisor long division, eight quotient bits per cycle.
`default_nettype none
module nce_alpha_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [nce_pkg::AQ_W-1:0] num_i,
  input  wire logic [2:0]               den_i,
  output logic                          done_o,
  output logic [nce_pkg::AQ_W-1:0]      quo_o
);

  logic                     busy_q, done_q;
  logic [1:0]               cnt_q;
  logic [nce_pkg::AQ_W-1:0] sh_q, sh_d;
  logic [2:0]               rem_q, rem_d, den_q;
  logic [3:0]               rs;

  // Shift numerator bits out the top, quotient bits in the bottom.
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    rs    = '0;
    for (int k = 0; k < nce_pkg::ADIV_STEPS; k++) begin
      rs   = {rem_d, sh_d[nce_pkg::AQ_W-1]};
      sh_d = {sh_d[nce_pkg::AQ_W-2:0], 1'b0};
      if (rs >= {1'b0, den_q}) begin
        rem_d   = 3'(rs - {1'b0, den_q});
        sh_d[0] = 1'b1;
      end else begin
        rem_d = rs[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'(nce_pkg::ADIV_CYC - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 2'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule
`default_nettype wire

// ----- hdl/nce_out_div.sv -----
// Output divider: three-lane restoring division h*ONE/w with saturation.
`default_nettype none
module nce_out_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [2:0][nce_pkg::D_W-1:0]          h_i,
  input  wire logic [nce_pkg::W_W-1:0]               w_i,
  output logic                                       done_o,
  output logic [2:0][nce_pkg::COORD_W-1:0]           res_o
);

  localparam int QW = nce_pkg::COORD_W;

  logic                     busy_q, done_q;
  logic [4:0]               cnt_q;
  logic [nce_pkg::W_W-1:0]  w_q;
  logic [nce_pkg::W_W-1:0]  rem_q [3];
  logic [nce_pkg::W_W-1:0]  rem_d [3];
  logic [QW-1:0]            q_q   [3];
  logic [QW-1:0]            q_d   [3];
  logic [nce_pkg::W_W:0]    rs    [3];
  logic [nce_pkg::D_W-1:0]  mag   [3];
  logic                     neg_q [3];
  logic                     sat_q [3];
  logic                     sat_d [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l]   = h_i[l][nce_pkg::D_W-1] ? nce_pkg::D_W'(-h_i[l]) : h_i[l];
      sat_d[l] = mag[l] >= {w_i, {nce_pkg::FRAC_BITS{1'b0}}};
      rs[l]    = {rem_q[l], q_q[l][QW-1]};
      q_d[l]   = {q_q[l][QW-2:0], 1'b0};
      if (rs[l] >= {1'b0, w_q}) begin
        rem_d[l]  = nce_pkg::W_W'(rs[l] - {1'b0, w_q});
        q_d[l][0] = 1'b1;
      end else begin
        rem_d[l] = rs[l][nce_pkg::W_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q <= w_i;
      for (int l = 0; l < 3; l++) begin
        neg_q[l] <= h_i[l][nce_pkg::D_W-1];
        sat_q[l] <= sat_d[l];
        rem_q[l] <= mag[l][nce_pkg::D_W-1:nce_pkg::FRAC_BITS];
        q_q[l]   <= {mag[l][nce_pkg::FRAC_BITS-1:0], {(QW-nce_pkg::FRAC_BITS){1'b0}}};
      end
    end else if (busy_q) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[l] <= rem_d[l];
        q_q[l]   <= q_d[l];
      end
    end
  end

  // Apply sign and clamp to the signed 32-bit range.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (sat_q[l]) begin
        res_o[l] = neg_q[l] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else if (neg_q[l]) begin
        res_o[l] = (q_q[l] > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : -q_q[l];
      end else begin
        res_o[l] = (q_q[l] > {1'b0, {(QW-1){1'b1}}}) ? {1'b0, {(QW-1){1'b1}}} : q_q[l];
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hdl/nurbs_curve_evaluate_top.sv -----
// Top level of the NURBS curve evaluator: control point memory, work memory, sequencer.
`default_nettype none
// Each input beat either writes one control point (x, y, z, weight) into a
// 64-entry point memory or evaluates the curve at param_t, clamped to [0,1],
// with a clamped uniform knot vector set by num_points and curve_degree. A
// write beat goes from accept straight to output. An evaluation of degree p
// loads the p+1 control points (one memory read each), then runs the
// p*(p+1)/2 de Boor blends (work memory read, alpha divide, multiply
// pipeline over the four components, write back), with accept, final read,
// finish and output around them, and in rational mode the three-lane output
// divide before output. The sequencer handles one beat at a time; the output
// register lets the next beat be taken while a result waits. Coordinates
// saturate to signed Q16.16. Status: 0 ok, 1 bad num_points/curve_degree,
// 2 zero weight on write (entry kept), 3 zero or negative homogeneous
// weight. Reading entries never written gives undefined coordinates.
// Configure through the APB port (0x0 num_points, 0x4 curve_degree, 0x8
// rational_mode) only while idle.
module nurbs_curve_evaluate_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [3:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           cmd_i,
  input  wire logic [nce_pkg::PIDX_W-1:0]     entry_index_i,
  input  wire logic signed [31:0]             coord_x_i,
  input  wire logic signed [31:0]             coord_y_i,
  input  wire logic signed [31:0]             coord_z_i,
  input  wire logic [31:0]                    point_weight_i,
  input  wire logic signed [31:0]             param_t_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [31:0]                  out_x_o,
  output logic signed [31:0]                  out_y_o,
  output logic signed [31:0]                  out_z_o,
  output logic [1:0]                          status_o
);

  localparam int DW = nce_pkg::D_W;
  localparam int FB = nce_pkg::FRAC_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_LRD   = 12'b0000_0000_0010,
    S_LCALC = 12'b0000_0000_0100,
    S_BRD   = 12'b0000_0000_1000,
    S_BDIV  = 12'b0000_0001_0000,
    S_BMUL  = 12'b0000_0010_0000,
    S_BWR   = 12'b0000_0100_0000,
    S_FRD   = 12'b0000_1000_0000,
    S_FIN   = 12'b0001_0000_0000,
    S_FDIV  = 12'b0010_0000_0000,
    S_OUT   = 12'b0100_0000_0000,
    S_HOLD  = 12'b1000_0000_0000
  } nce_state_e;

  nce_state_e state_q, state_d;

  // ---------------------------------------------------------------- config
  logic [nce_pkg::NPTS_W-1:0] num_points_q;
  logic [nce_pkg::DEG_W-1:0]  curve_degree_q;
  logic                       rational_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= 7'd4;
      curve_degree_q <= 3'd3;
      rational_q     <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        nce_pkg::REG_NUM_POINTS:   num_points_q   <= pwdata[nce_pkg::NPTS_W-1:0];
        nce_pkg::REG_CURVE_DEGREE: curve_degree_q <= pwdata[nce_pkg::DEG_W-1:0];
        nce_pkg::REG_RATIONAL:     rational_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      nce_pkg::REG_NUM_POINTS:   prdata = {25'b0, num_points_q};
      nce_pkg::REG_CURVE_DEGREE: prdata = {29'b0, curve_degree_q};
      nce_pkg::REG_RATIONAL:     prdata = {31'b0, rational_q};
      default:                   prdata = '0;
    endcase
  end

  // ------------------------------------------------------- span and scale
  logic                       in_acc;
  logic                       cfg_bad;
  logic [nce_pkg::NPTS_W-1:0] m_w;
  logic [nce_pkg::ONE_W-1:0]  t_cl;
  logic [nce_pkg::AQ_W-1:0]   tm_w, tm_q;
  logic [nce_pkg::NPTS_W:0]   tm_hi;
  logic [nce_pkg::NPTS_W:0]   base_w;
  logic [nce_pkg::PIDX_W-1:0] base_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign cfg_bad = (num_points_q < 7'd2) ||
                   (num_points_q > nce_pkg::NPTS_W'(nce_pkg::MAX_POINTS)) ||
                   (curve_degree_q == '0) ||
                   ({4'b0, curve_degree_q} >= num_points_q);
  assign m_w = num_points_q - {4'b0, curve_degree_q};

  always_comb begin
    if (param_t_i[31]) begin
      t_cl = '0;
    end else if (param_t_i > $signed(32'(nce_pkg::ONE_Q))) begin
      t_cl = nce_pkg::ONE_Q;
    end else begin
      t_cl = param_t_i[nce_pkg::ONE_W-1:0];
    end
    tm_w  = nce_pkg::AQ_W'(t_cl) * nce_pkg::AQ_W'(m_w);
    tm_hi = tm_w[nce_pkg::AQ_W-1:FB];
    // Span capped at m-1 (m = num_points - curve_degree) keeps the window start below m.
    base_w = (tm_hi > {1'b0, m_w - 7'd1}) ? {1'b0, m_w - 7'd1} : tm_hi;
  end

  // ----------------------------------------------------------- memories
  logic [4*32-1:0]            pmem [nce_pkg::MAX_POINTS];
  logic [4*32-1:0]            pmem_q;
  nce_pkg::nce_hpoint_t       wmem [nce_pkg::MAX_DEGREE+1];
  nce_pkg::nce_hpoint_t       rd0_q, rd1_q, wdata;
  logic                       wmem_we;
  logic [2:0]                 wmem_wa;
  logic [2:0]                 jc_q, jb_q, r_q;
  logic [nce_pkg::PIDX_W-1:0] pidx;

  assign pidx = base_q + nce_pkg::PIDX_W'(jc_q);

  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_i == nce_pkg::CMD_WRITE && point_weight_i != '0) begin
      pmem[entry_index_i] <= {coord_x_i, coord_y_i, coord_z_i, point_weight_i};
    end
    if (state_q == S_LRD) begin
      pmem_q <= pmem[pidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      wmem[wmem_wa] <= wdata;
    end
    if (state_q == S_BRD) begin
      rd0_q <= wmem[jb_q - 3'd1];
      rd1_q <= wmem[jb_q];
    end else if (state_q == S_FRD) begin
      rd1_q <= wmem[curve_degree_q];
    end
  end

  // -------------------------------------------- homogeneous point load
  logic signed [31:0]          px, py, pz;
  logic [31:0]                 pw;
  logic signed [64:0]          prd   [3];
  logic signed [64:0]          prd_r [3];
  nce_pkg::nce_hpoint_t        hload;

  assign px = pmem_q[127:96];
  assign py = pmem_q[95:64];
  assign pz = pmem_q[63:32];
  assign pw = pmem_q[31:0];

  always_comb begin
    prd[0] = px * $signed({1'b0, pw});
    prd[1] = py * $signed({1'b0, pw});
    prd[2] = pz * $signed({1'b0, pw});
    for (int c = 0; c < 3; c++) begin
      prd_r[c] = prd[c] + $signed(65'(1) << (FB - 1));
      hload[c] = {prd_r[c][64], prd_r[c][64:FB]};
    end
    hload[3] = DW'(pw);
    if (!rational_q) begin
      hload[0] = DW'(px);
      hload[1] = DW'(py);
      hload[2] = DW'(pz);
      hload[3] = DW'(nce_pkg::ONE_Q);
    end
  end

  // ------------------------------------------------------- knot alpha
  logic [6:0]                left;
  logic signed [8:0]         la, lb;
  logic [6:0]                ka, kb, den7;
  logic signed [nce_pkg::AQ_W:0] num_s;
  logic [nce_pkg::AQ_W-1:0]  num_w;
  logic                      den_zero_q;
  logic                      adiv_done;
  logic [nce_pkg::AQ_W-1:0]  adiv_quo;
  logic [nce_pkg::ONE_W-1:0] alpha_q;

  always_comb begin
    left = {1'b0, base_q} + {4'b0, jb_q};
    la   = $signed({2'b0, left}) - $signed({6'b0, curve_degree_q});
    lb   = $signed({2'b0, left}) + 9'sd1 - $signed({6'b0, r_q});
    ka   = la[8] ? '0 : ((la[7:0] > {1'b0, m_w}) ? m_w : la[6:0]);
    kb   = lb[8] ? '0 : ((lb[7:0] > {1'b0, m_w}) ? m_w : lb[6:0]);
    den7 = kb - ka;
    num_s = $signed({1'b0, tm_q}) - $signed({1'b0, nce_pkg::AQ_W'(ka) << FB});
    num_w = num_s[nce_pkg::AQ_W] ? '0 : num_s[nce_pkg::AQ_W-1:0];
  end

  nce_alpha_div u_alpha_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_BRD),
    .num_i   (num_w),
    .den_i   (den7[2:0]),
    .done_o  (adiv_done),
    .quo_o   (adiv_quo)
  );

  // ------------------------------------------------------ blend pipeline
  logic [2:0]                cc_q;
  logic signed [67:0]        pa_q, pb_q;
  logic signed [68:0]        bsum;
  logic [3:0][DW-1:0]        bl_q;

  assign bsum = pa_q + pb_q + $signed(69'(1) << (FB - 1));

  always_ff @(posedge clk_i) begin
    if (state_q == S_BDIV && adiv_done) begin
      if (den_zero_q) begin
        alpha_q <= '0;
      end else if (adiv_quo > nce_pkg::AQ_W'(nce_pkg::ONE_Q)) begin
        alpha_q <= nce_pkg::ONE_Q;
      end else begin
        alpha_q <= adiv_quo[nce_pkg::ONE_W-1:0];
      end
    end
    if (state_q == S_BRD) begin
      den_zero_q <= (den7 == '0);
    end
    if (state_q == S_BMUL) begin
      // Products of component cc, and the sum of component cc-1 from the products registered the cycle before.
      pa_q <= $signed(rd0_q[cc_q[1:0]]) * $signed({1'b0, nce_pkg::ONE_Q - alpha_q});
      pb_q <= $signed(rd1_q[cc_q[1:0]]) * $signed({1'b0, alpha_q});
      if (cc_q != '0) begin
        bl_q[2'(cc_q - 3'd1)] <= bsum[DW+FB-1:FB];
      end
    end
  end

  // ------------------------------------------------------ output divide
  logic                         odiv_done;
  logic [2:0][31:0]             odiv_res;
  logic signed [DW-1:0]         fw;

  assign fw = rd1_q[3];

  nce_out_div u_out_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_FIN && rational_q && !(fw[DW-1] || fw == '0)),
    .h_i     (rd1_q[2:0]),
    .w_i     (fw[nce_pkg::W_W-1:0]),
    .done_o  (odiv_done),
    .res_o   (odiv_res)
  );

  // ---------------------------------------------------------- sequencer
  logic [31:0]  res_x_q, res_y_q, res_z_q;
  logic [1:0]   res_st_q;
  logic         out_free;

  assign out_free = ~out_valid_o | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    wmem_we = 1'b0;
    wmem_wa = jc_q;
    wdata   = hload;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == nce_pkg::CMD_WRITE || cfg_bad) begin
            state_d = S_OUT;
          end else begin
            state_d = S_LRD;
          end
        end
      end
      S_LRD: state_d = S_LCALC;
      S_LCALC: begin
        wmem_we = 1'b1;
        state_d = (jc_q == curve_degree_q) ? S_BRD : S_LRD;
      end
      S_BRD: state_d = S_BDIV;
      S_BDIV: begin
        if (adiv_done) begin
          state_d = S_BMUL;
        end
      end
      S_BMUL: begin
        if (cc_q == 3'd4) begin
          state_d = S_BWR;
        end
      end
      S_BWR: begin
        wmem_we = 1'b1;
        wmem_wa = jb_q;
        wdata   = bl_q;
        if (jb_q == r_q && r_q == curve_degree_q) begin
          state_d = S_FRD;
        end else begin
          state_d = S_BRD;
        end
      end
      S_FRD: state_d = S_FIN;
      S_FIN: begin
        if (rational_q && !(fw[DW-1] || fw == '0)) begin
          state_d = S_FDIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FDIV: begin
        if (odiv_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      jc_q    <= '0;
      jb_q    <= '0;
      r_q     <= '0;
      cc_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          jc_q <= '0;
        end
        S_LCALC: begin
          jc_q <= jc_q + 3'd1;
          r_q  <= 3'd1;
          jb_q <= curve_degree_q;
        end
        S_BDIV: begin
          cc_q <= '0;
        end
        S_BMUL: begin
          cc_q <= cc_q + 3'd1;
        end
        S_BWR: begin
          // Walk j down to r, then start the next round at the top.
          if (jb_q == r_q) begin
            r_q  <= r_q + 3'd1;
            jb_q <= curve_degree_q;
          end else begin
            jb_q <= jb_q - 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tm_q     <= tm_w;
      base_q   <= base_w[nce_pkg::PIDX_W-1:0];
      res_x_q  <= '0;
      res_y_q  <= '0;
      res_z_q  <= '0;
      res_st_q <= nce_pkg::ST_OK;
      if (cmd_i == nce_pkg::CMD_WRITE) begin
        if (point_weight_i == '0) begin
          res_st_q <= nce_pkg::ST_WEIGHT_ZERO;
        end
      end else if (cfg_bad) begin
        res_st_q <= nce_pkg::ST_BAD_CFG;
      end
    end
    if (state_q == S_FIN) begin
      if (!rational_q) begin
        res_x_q <= nce_pkg::sat32(rd1_q[0]);
        res_y_q <= nce_pkg::sat32(rd1_q[1]);
        res_z_q <= nce_pkg::sat32(rd1_q[2]);
      end else if (fw[DW-1] || fw == '0) begin
        res_st_q <= nce_pkg::ST_HOMOG_ZERO;
      end
    end
    if (state_q == S_FDIV && odiv_done) begin
      res_x_q <= odiv_res[0];
      res_y_q <= odiv_res[1];
      res_z_q <= odiv_res[2];
    end
  end

  // --------------------------------------------------------- output beat
  logic out_load;

  assign out_load = (state_q == S_OUT || state_q == S_HOLD) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_o  <= res_x_q;
      out_y_o  <= res_y_q;
      out_z_o  <= res_z_q;
      status_o <= res_st_q;
    end
  end

  // ---------------------------------------------------------- assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != nce_pkg::ST_OK |->
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("error status with nonzero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == nce_pkg::ST_HOMOG_ZERO |-> rational_q)
    else $error("zero homogeneous weight reported in plain mode");

endmodule
`default_nettype wire
